[hdl/psfl_pkg.sv]
// Package: shared types, constants and helpers of the slot pool allocator.
`default_nettype none
package psfl_pkg;
  localparam int NUM_BLOCKS = 8;
  localparam int MAX_SLOTS = 512;
  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int SW = $clog2(MAX_SLOTS);
  localparam int AW = BW + SW;
  localparam int LW = AW + 1;
  localparam int BLW = BW + 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int QDEPTH = 2;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [LW-1:0] NO_SLOT = LW'(NUM_BLOCKS * MAX_SLOTS);
  localparam logic [BLW-1:0] NO_BLOCK = BLW'(NUM_BLOCKS);

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] release_block;
    logic [8:0] release_slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0] got_block;
    logic [8:0] got_slot;
    logic       status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]    op;
    logic          rel_ok;
    logic [AW-1:0] addr;
  } cmd_t;

  // 4088 / max(b,8): quotient search over a power of two ladder, constant dividend
  function automatic logic [CW-1:0] calc_slots(input logic [15:0] bytes);
    logic [15:0] b;
    logic [12:0] rem;
    logic [12:0] q;
    b = (bytes > 16'd8) ? bytes : 16'd8;
    rem = 13'd4088;
    q = '0;
    for (int i = 9; i >= 0; i--) begin
      if ({3'd0, rem} >= ({16'd0, b} << i)) begin
        rem = rem - 13'(b << i);
        q[i] = 1'b1;
      end
    end
    if (q < 13'd8) q = 13'd8;
    if (q > 13'(MAX_SLOTS)) q = 13'(MAX_SLOTS);
    return CW'(q);
  endfunction
endpackage
`default_nettype wire

[hdl/pool_slot_free_list_allocator_core.sv]
// Release links the slot in from idle; alloc from the list reads the link memory (READ, POP);
// alloc with block init first walks the block's slots (INIT); clear walks used blocks (CLEAR).
// Throughput: one transaction at a time in the back end, set by the link memory
// read-modify-write and block/clear walks; a 2-entry queue lets the input side run ahead.
// An object_bytes write recomputes slots/block with a serial divider; commands wait meanwhile.
// Reset: lists empty, no blocks created, object_bytes 8; link memory is not cleared.
`default_nettype none
module pool_slot_free_list_allocator_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire psfl_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output psfl_pkg::out_item_t       out_data,
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [1:0]           cfg_paddr,
  input  wire logic [31:0]          cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  localparam int CW = psfl_pkg::CW;
  localparam logic [12:0] DIV_NUM = 13'd4088;
  localparam logic [3:0] DIV_LAST = 4'd9;

  logic [15:0] obj_r;
  logic [CW-1:0] spb_r;
  logic cmd_valid, cmd_ready;
  logic bk_valid, bk_ready;
  psfl_pkg::cmd_t cmd_data;

  logic cfg_wr;
  logic [15:0] div_b;
  logic div_busy_r;
  logic [3:0] div_cnt_r;
  logic [12:0] div_rem_r;
  logic [24:0] div_dvs_r;
  logic [CW-1:0] div_q_r;
  logic div_fit;
  logic [CW-1:0] div_q_step;
  logic [CW-1:0] spb_step;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {16'd0, obj_r} : 32'd0;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0;

  assign div_b = (cfg_pwdata[15:0] > 16'd8) ? cfg_pwdata[15:0] : 16'd8;
  assign div_fit = ({12'd0, div_rem_r} >= div_dvs_r);
  assign div_q_step = {div_q_r[CW-2:0], div_fit};
  assign spb_step = (div_q_step < CW'(8)) ? CW'(8)
                  : (div_q_step > CW'(psfl_pkg::MAX_SLOTS)) ? CW'(psfl_pkg::MAX_SLOTS)
                  : div_q_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_r <= 16'd8;
      spb_r <= psfl_pkg::calc_slots(16'd8);
      div_busy_r <= 1'b0;
      div_cnt_r <= '0;
      div_rem_r <= '0;
      div_dvs_r <= '0;
      div_q_r <= '0;
    end else if (cfg_wr) begin
      obj_r <= cfg_pwdata[15:0];
      div_busy_r <= 1'b1;
      div_cnt_r <= DIV_LAST;
      div_rem_r <= DIV_NUM;
      div_dvs_r <= {div_b, 9'd0};
      div_q_r <= '0;
    end else if (div_busy_r) begin
      if (div_fit) div_rem_r <= div_rem_r - div_dvs_r[12:0];
      div_q_r <= div_q_step;
      div_dvs_r <= div_dvs_r >> 1;
      div_cnt_r <= div_cnt_r - 1'b1;
      if (div_cnt_r == '0) begin
        div_busy_r <= 1'b0;
        spb_r <= spb_step;
      end
    end
  end

  assign bk_valid = cmd_valid && !div_busy_r;
  assign cmd_ready = bk_ready && !div_busy_r;

  psfl_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
  );

  psfl_back u_back (
    .clk(clk), .rst_n(rst_n), .slots_per_block(spb_r),
    .cmd_valid(bk_valid), .cmd_ready(bk_ready), .cmd_data(cmd_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire

[hdl/psfl_ram.sv]
// Generic single-port-write RAM with one registered read port.
`default_nettype none
module psfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/psfl_front.sv]
// Front end: accepts transactions, classifies them and queues commands.
`default_nettype none
module psfl_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire psfl_pkg::in_item_t in_data,
  output logic                  cmd_valid,
  input  wire logic             cmd_ready,
  output psfl_pkg::cmd_t        cmd_data
);
  localparam int QW = $clog2(psfl_pkg::QDEPTH);
  psfl_pkg::cmd_t q_r [psfl_pkg::QDEPTH];
  logic [QW-1:0] wp_r, rp_r;
  logic [QW:0] cnt_r;
  psfl_pkg::cmd_t c;
  logic push, pop;

  always_comb begin
    c.op = in_data.operation;
    c.rel_ok = (32'(in_data.release_block) < psfl_pkg::NUM_BLOCKS)
               && (32'(in_data.release_slot) < psfl_pkg::MAX_SLOTS);
    c.addr = {in_data.release_block, in_data.release_slot};
  end

  assign in_ready = (cnt_r != (QW+1)'(psfl_pkg::QDEPTH));
  assign push = in_valid && in_ready;
  assign cmd_valid = (cnt_r != '0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd_data = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QW+1)'(push) - (QW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

[hdl/psfl_back.sv]
// Back end: executes alloc, release and clear against the link memory.
`default_nettype none
module psfl_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [psfl_pkg::CW-1:0]     slots_per_block,
  input  wire logic                        cmd_valid,
  output logic                             cmd_ready,
  input  wire psfl_pkg::cmd_t              cmd_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output psfl_pkg::out_item_t              out_data
);
  localparam int AW = psfl_pkg::AW;
  localparam int LW = psfl_pkg::LW;
  localparam int BW = psfl_pkg::BW;
  localparam int BLW = psfl_pkg::BLW;
  localparam int SW = psfl_pkg::SW;
  localparam int CW = psfl_pkg::CW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_POP = 3'd2;
  localparam logic [2:0] ST_INIT = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;
  localparam logic [2:0] ST_OUT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [BLW-1:0] used_r, used_nxt, spare_r, spare_nxt, clr_r, clr_nxt;
  logic [BLW-1:0] created_r, created_nxt;
  logic [BLW-1:0] blink_r [psfl_pkg::NUM_BLOCKS];
  logic [BLW-1:0] bl_wdata;
  logic [BW-1:0] bl_waddr;
  logic bl_we;
  logic [BW-1:0] blk_r, blk_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [3:0] guard_r, guard_nxt;
  psfl_pkg::out_item_t res_r, res_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [LW-1:0] wdata, rdata;

  psfl_ram #(.WIDTH(LW), .DEPTH(psfl_pkg::NUM_BLOCKS * psfl_pkg::MAX_SLOTS)) u_links (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign cmd_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data = res_r;

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r;
    used_nxt = used_r;
    spare_nxt = spare_r;
    clr_nxt = clr_r;
    created_nxt = created_r;
    blk_nxt = blk_r;
    idx_nxt = idx_r;
    guard_nxt = guard_r;
    res_nxt = res_r;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = head_r[AW-1:0];
    bl_we = 1'b0;
    bl_waddr = '0;
    bl_wdata = '0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          res_nxt = '0;
          state_nxt = ST_OUT;
          case (cmd_data.op)
            psfl_pkg::OP_ALLOC: begin
              if (head_r < psfl_pkg::NO_SLOT) begin
                state_nxt = ST_READ;
              end else if (spare_r < psfl_pkg::NO_BLOCK) begin
                blk_nxt = spare_r[BW-1:0];
                spare_nxt = (blink_r[spare_r[BW-1:0]] > psfl_pkg::NO_BLOCK)
                            ? psfl_pkg::NO_BLOCK : blink_r[spare_r[BW-1:0]];
                idx_nxt = '0;
                state_nxt = ST_INIT;
              end else if (created_r < psfl_pkg::NO_BLOCK) begin
                blk_nxt = created_r[BW-1:0];
                created_nxt = created_r + 1'b1;
                idx_nxt = '0;
                state_nxt = ST_INIT;
              end else begin
                res_nxt.status = 1'b1;
              end
              if (state_nxt == ST_INIT) begin
                bl_we = 1'b1;
                bl_waddr = blk_nxt;
                bl_wdata = used_r;
                used_nxt = {1'b0, blk_nxt};
              end
            end
            psfl_pkg::OP_RELEASE: begin
              if (cmd_data.rel_ok) begin
                we = 1'b1;
                waddr = cmd_data.addr;
                wdata = head_r;
                head_nxt = {1'b0, cmd_data.addr};
              end
            end
            psfl_pkg::OP_CLEAR: begin
              clr_nxt = used_r;
              guard_nxt = '0;
              state_nxt = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        we = 1'b1;
        waddr = {blk_r, idx_r[SW-1:0]};
        if (idx_r + 1'b1 >= slots_per_block) begin
          wdata = psfl_pkg::NO_SLOT;
          head_nxt = {1'b0, blk_r, {SW{1'b0}}};
          state_nxt = ST_READ;
        end else begin
          wdata = {1'b0, blk_r, idx_r[SW-1:0] + 1'b1};
        end
        idx_nxt = idx_r + 1'b1;
      end
      ST_READ: state_nxt = ST_POP;
      ST_POP: begin
        res_nxt.got_block = 3'(head_r[AW-1:SW]);
        res_nxt.got_slot = 9'(head_r[SW-1:0]);
        head_nxt = (rdata > psfl_pkg::NO_SLOT) ? psfl_pkg::NO_SLOT : rdata;
        state_nxt = ST_OUT;
      end
      ST_CLEAR: begin
        if (clr_r < psfl_pkg::NO_BLOCK && 32'(guard_r) < psfl_pkg::NUM_BLOCKS) begin
          bl_we = 1'b1;
          bl_waddr = clr_r[BW-1:0];
          bl_wdata = spare_r;
          spare_nxt = clr_r;
          clr_nxt = blink_r[clr_r[BW-1:0]];
          guard_nxt = guard_r + 1'b1;
        end else begin
          used_nxt = psfl_pkg::NO_BLOCK;
          head_nxt = psfl_pkg::NO_SLOT;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bl_we) blink_r[bl_waddr] <= bl_wdata;
    blk_r <= blk_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    clr_r <= clr_nxt;
    guard_r <= guard_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r <= psfl_pkg::NO_SLOT;
      used_r <= psfl_pkg::NO_BLOCK;
      spare_r <= psfl_pkg::NO_BLOCK;
      created_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      used_r <= used_nxt;
      spare_r <= spare_nxt;
      created_r <= created_nxt;
    end
  end
endmodule
`default_nettype wire

[test/tb_pool_slot_free_list_allocator_core.sv]
// Testbench for the slot pool allocator core: directed table plus random traffic, predictor-checked.
`default_nettype none
module tb_pool_slot_free_list_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BLOCKS = psfl_pkg::NUM_BLOCKS;
  localparam int MAX_SLOTS = psfl_pkg::MAX_SLOTS;
  localparam int REG_OBJECT_BYTES = 0;
  localparam int POOL_END = NUM_BLOCKS * MAX_SLOTS;
  localparam int STUCK_LIMIT = 20000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] op;
    int         blk;
    int         slot;
    bit         typed;
    psfl_pkg::out_item_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  psfl_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  psfl_pkg::out_item_t out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pool_slot_free_list_allocator_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // allocator state as predicted
  int pool_next [POOL_END];
  int slot_head;
  int blk_next [NUM_BLOCKS];
  int used_head;
  int spare_head;
  int made_blocks;
  int slots_per_blk;
  int handed_q[$];
  psfl_pkg::out_item_t alloc_q[$];

  int errors = 0;
  int stuck = 0;
  int n_alloc = 0, n_fail = 0, n_release = 0, n_clear = 0, n_other = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  function automatic int slots_for(int bytes);
    int b, n;
    b = (bytes > 8) ? bytes : 8;
    n = 4088 / b;
    if (n < 8) n = 8;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    return n;
  endfunction

  function automatic psfl_pkg::out_item_t predict_alloc(psfl_pkg::in_item_t t);
    psfl_pkg::out_item_t r;
    int h, nx, blk, a;
    bit ok;
    r = '0;
    ok = 1'b1;
    case (t.operation)
      psfl_pkg::OP_ALLOC: begin
        n_alloc++;
        if (slot_head >= POOL_END) begin
          if (spare_head < NUM_BLOCKS) begin
            blk = spare_head;
            spare_head = blk_next[blk];
            if (spare_head > NUM_BLOCKS) spare_head = NUM_BLOCKS;
          end else if (made_blocks < NUM_BLOCKS) begin
            blk = made_blocks;
            made_blocks++;
          end else begin
            ok = 1'b0;
          end
          if (ok) begin
            blk_next[blk] = used_head;
            used_head = blk;
            for (int i = 0; i < slots_per_blk - 1; i++)
              pool_next[blk * MAX_SLOTS + i] = blk * MAX_SLOTS + i + 1;
            pool_next[blk * MAX_SLOTS + slots_per_blk - 1] = POOL_END;
            slot_head = blk * MAX_SLOTS;
          end
        end
        if (ok) begin
          h = slot_head;
          nx = pool_next[h];
          slot_head = (nx > POOL_END) ? POOL_END : nx;
          r.got_block = 3'(h / MAX_SLOTS);
          r.got_slot = 9'(h % MAX_SLOTS);
          handed_q.push_back(h);
        end else begin
          r.status = 1'b1;
          n_fail++;
        end
      end
      psfl_pkg::OP_RELEASE: begin
        n_release++;
        a = int'(t.release_block) * MAX_SLOTS + int'(t.release_slot);
        pool_next[a] = slot_head;
        slot_head = a;
      end
      psfl_pkg::OP_CLEAR: begin
        n_clear++;
        blk = used_head;
        for (int g = 0; g < NUM_BLOCKS && blk < NUM_BLOCKS; g++) begin
          nx = blk_next[blk];
          blk_next[blk] = spare_head;
          spare_head = blk;
          blk = nx;
        end
        used_head = NUM_BLOCKS;
        slot_head = POOL_END;
      end
      default: n_other++;
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(15, 60);
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send(psfl_pkg::in_item_t t, bit typed = 1'b0,
                      psfl_pkg::out_item_t want = '0);
    psfl_pkg::out_item_t p;
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_alloc(t);
    alloc_q.push_back(typed ? want : p);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (alloc_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_object_bytes(int v);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= 2'(4 * REG_OBJECT_BYTES); cfg_pwdata <= 32'(v);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[15:0] !== 16'(v)) report("object_bytes readback", cfg_prdata[15:0], v);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
    slots_per_blk = slots_for(v & 32'hFFFF);
  endtask

  task automatic random_phase(int count, int alloc_pct, int clear_pct);
    psfl_pkg::in_item_t t;
    int r, k;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      t.release_block = 3'($urandom);
      t.release_slot = 9'($urandom);
      if (r < alloc_pct) begin
        t.operation = psfl_pkg::OP_ALLOC;
      end else if (r < 100 - clear_pct - 8) begin
        t.operation = psfl_pkg::OP_RELEASE;
        if (handed_q.size() != 0 && $urandom_range(0, 4) != 0) begin
          k = $urandom_range(0, handed_q.size() - 1);
          t.release_block = 3'(handed_q[k] / MAX_SLOTS);
          t.release_slot = 9'(handed_q[k] % MAX_SLOTS);
          handed_q.delete(k);
        end
      end else if (r < 100 - clear_pct - 2) begin
        t.operation = 2'($urandom_range(0, 3));
      end else if (r < 100 - clear_pct) begin
        t.operation = OP_UNUSED;
      end else begin
        t.operation = psfl_pkg::OP_CLEAR;
        handed_q.delete();
      end
      send(t);
    end
    steady = 1'b0;
  endtask

  row_t rows[$];

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (alloc_q.size() == 0) begin
        report("unexpected result, got_slot", out_data.got_slot, -1);
      end else begin
        psfl_pkg::out_item_t w;
        w = alloc_q.pop_front();
        if (out_data.got_block !== w.got_block) report("got_block", out_data.got_block, w.got_block);
        if (out_data.got_slot !== w.got_slot) report("got_slot", out_data.got_slot, w.got_slot);
        if (out_data.status !== w.status) report("status", out_data.status, w.status);
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck > STUCK_LIMIT) begin
      $display("watchdog expired with %0d results pending", alloc_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (399) @(negedge clk);
        hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len() - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    psfl_pkg::in_item_t t;
    slots_per_blk = slots_for(8);
    slot_head = POOL_END;
    used_head = NUM_BLOCKS;
    spare_head = NUM_BLOCKS;
    made_blocks = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    rows = '{
      '{psfl_pkg::OP_ALLOC,   0,   0, 1, '{3'd0, 9'd0,   1'b0}},
      '{psfl_pkg::OP_ALLOC,   0,   0, 1, '{3'd0, 9'd1,   1'b0}},
      '{psfl_pkg::OP_RELEASE, 7, 511, 1, '{3'd0, 9'd0,   1'b0}},
      '{OP_UNUSED,            7, 511, 1, '{3'd0, 9'd0,   1'b0}},
      '{psfl_pkg::OP_ALLOC,   5, 300, 1, '{3'd7, 9'd511, 1'b0}},
      '{psfl_pkg::OP_ALLOC,   0,   0, 1, '{3'd0, 9'd2,   1'b0}},
      '{psfl_pkg::OP_RELEASE, 0,   0, 1, '{3'd0, 9'd0,   1'b0}},
      '{psfl_pkg::OP_ALLOC,   0,   0, 1, '{3'd0, 9'd0,   1'b0}},
      '{psfl_pkg::OP_CLEAR,   2, 170, 1, '{3'd0, 9'd0,   1'b0}},
      '{psfl_pkg::OP_ALLOC,   0,   0, 1, '{3'd0, 9'd0,   1'b0}},
      '{psfl_pkg::OP_ALLOC,   0,   0, 1, '{3'd0, 9'd1,   1'b0}},
      '{psfl_pkg::OP_RELEASE, 3, 255, 0, '0},
      '{psfl_pkg::OP_RELEASE, 4, 256, 0, '0},
      '{psfl_pkg::OP_ALLOC,   0,   0, 0, '0},
      '{psfl_pkg::OP_ALLOC,   0,   0, 0, '0},
      '{psfl_pkg::OP_ALLOC,   0,   0, 0, '0},
      '{OP_UNUSED,            0,   0, 0, '0},
      '{psfl_pkg::OP_CLEAR,   0,   0, 0, '0},
      '{psfl_pkg::OP_ALLOC,   0,   0, 0, '0}
    };
    foreach (rows[i]) begin
      t.operation = rows[i].op;
      t.release_block = 3'(rows[i].blk);
      t.release_slot = 9'(rows[i].slot);
      send(t, rows[i].typed, rows[i].want);
    end
    drain();

    // live blocks keep their lists across the size changes below
    write_object_bytes(65535);
    random_phase(120, 82, 1);
    hold_req = 1'b1;
    random_phase(120, 80, 1);
    drain();
    write_object_bytes(1);
    random_phase(230, 60, 3);
    drain();
    write_object_bytes(4088);
    random_phase(230, 75, 2);
    drain();
    write_object_bytes(100);
    random_phase(100, 60, 3);
    hold_req = 1'b1;
    random_phase(130, 60, 3);
    drain();
    write_object_bytes(300);
    random_phase(230, 70, 2);
    drain();
    write_object_bytes(8);
    random_phase(230, 55, 4);
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d allocs (%0d out of blocks), %0d releases, %0d clears, %0d no-ops",
             n_alloc, n_fail, n_release, n_clear, n_other);
    $display("object sizes 8, 65535, 1, 4088, 100, 300 with mismatches: %0d", errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
